// ===== src/i2cbs_pkg.sv =====
// i2cbs_pkg: command codes, sequencer state and result types, sequence lengths
// for the I2C master bit sequencer. No dependencies.
`default_nettype none

package i2cbs_pkg;

  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_STOP  = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_RACK  = 3'd4;
  localparam logic [2:0] MODE_SACK  = 3'd5;

  localparam logic [1:0] PHASE_LAST = 2'd2;

  typedef struct packed {
    logic [2:0] active_mode;
    logic [4:0] step_count;
    logic [1:0] phase;
    logic       running;
    logic [7:0] shift_data;
    logic       ack_store;
    logic       scl_drive;
    logic       sda_drive;
  } seq_state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } step_result_t;

  function automatic logic [4:0] seq_len(input logic [2:0] m);
    logic [4:0] len;
    unique case (m)
      MODE_START: len = 5'd4;
      MODE_STOP:  len = 5'd3;
      MODE_WRITE: len = 5'd24;
      MODE_READ:  len = 5'd25;
      MODE_RACK:  len = 5'd4;
      MODE_SACK:  len = 5'd3;
      default:    len = 5'd1;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/i2cbs_step.sv =====
// i2cbs_step: next-state and result logic for one bus step.
// Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_step (
  input  var i2cbs_pkg::seq_state_t   cur,
  input  wire logic                   cmd_valid,
  input  wire logic [2:0]             mode,
  input  wire logic [7:0]             tx_byte,
  input  wire logic                   ack_level,
  input  wire logic                   sda_sampled,
  output i2cbs_pkg::seq_state_t       nxt,
  output i2cbs_pkg::step_result_t     res
);
  import i2cbs_pkg::*;

  seq_state_t st;
  logic [4:0] s;
  logic [1:0] ph;
  logic [5:0] s_inc;
  logic       busy;
  logic       done;
  logic [7:0] rx;

  always_comb begin
    st    = cur;
    busy  = 1'b0;
    done  = 1'b0;
    rx    = 8'd0;
    s     = 5'd0;
    ph    = 2'd0;
    s_inc = 6'd0;

    if (!cur.running && cmd_valid && (mode <= MODE_SACK)) begin
      st.active_mode = mode;
      st.step_count  = 5'd0;
      st.phase       = 2'd0;
      st.running     = 1'b1;
      if (mode == MODE_WRITE) begin
        st.shift_data = tx_byte;
      end else if (mode == MODE_READ) begin
        st.shift_data = 8'd0;
      end
    end

    if (st.running) begin
      s     = st.step_count;
      ph    = st.phase;
      busy  = 1'b1;
      s_inc = {1'b0, s} + 6'd1;
      st.phase = (ph == PHASE_LAST) ? 2'd0 : ph + 2'd1;
      unique case (st.active_mode)
        MODE_START: begin
          if (s == 5'd0) st.scl_drive = 1'b1;
          else if (s == 5'd1) st.sda_drive = 1'b1;
          else if (s == 5'd2) st.sda_drive = 1'b0;
          else st.scl_drive = 1'b0;
        end
        MODE_STOP: begin
          if (s == 5'd0) st.sda_drive = 1'b0;
          else if (s == 5'd1) st.scl_drive = 1'b1;
          else st.sda_drive = 1'b1;
        end
        MODE_WRITE: begin
          // MSB goes out on phase 0, data shifts left after the clock pulse
          if (ph == 2'd0) st.sda_drive = st.shift_data[7];
          else if (ph == 2'd1) st.scl_drive = 1'b1;
          else begin
            st.scl_drive  = 1'b0;
            st.shift_data = {st.shift_data[6:0], 1'b0};
          end
        end
        MODE_READ: begin
          if (s == 5'd0) begin
            st.sda_drive = 1'b1;
            st.phase     = 2'd0;
          end else if (ph == 2'd0) st.scl_drive = 1'b1;
          else if (ph == 2'd1) st.shift_data = {st.shift_data[6:0], sda_sampled};
          else st.scl_drive = 1'b0;
        end
        MODE_RACK: begin
          if (s == 5'd0) st.sda_drive = 1'b1;
          else if (s == 5'd1) st.scl_drive = 1'b1;
          else if (s == 5'd2) st.ack_store = sda_sampled;
          else st.scl_drive = 1'b0;
        end
        default: begin
          if (s == 5'd0) st.sda_drive = ack_level;
          else if (s == 5'd1) st.scl_drive = 1'b1;
          else st.scl_drive = 1'b0;
        end
      endcase

      if (s_inc >= {1'b0, seq_len(st.active_mode)}) begin
        done          = 1'b1;
        if (st.active_mode == MODE_READ) rx = st.shift_data;
        st.running    = 1'b0;
        st.step_count = 5'd0;
      end else begin
        st.step_count = s_inc[4:0];
      end
    end

    nxt           = st;
    res.scl_level = st.scl_drive;
    res.sda_level = st.sda_drive;
    res.busy_res  = busy;
    res.done_res  = done;
    res.rx_byte   = rx;
    res.ack_seen  = st.ack_store;
  end

endmodule

`default_nettype wire

// ===== src/i2c_master_bit_sequencer.sv =====
// i2c_master_bit_sequencer: I2C master that drives SCL and open-drain SDA one
// bus step per input word. Depends on i2cbs_pkg and i2cbs_step.
//
// Usage: each input word is one bus step (one delay slot). It carries an
// optional command (cmd_valid, mode, tx_byte, ack_level) and the SDA level
// sampled during the step. Each accepted word yields exactly one result word
// with the SCL/SDA levels to drive, busy/done flags, the received byte on the
// final step of a read, and the last acknowledge level seen.
// Channels: in_valid/in_stall and out_valid/out_stall; a word moves at a
// clock edge with valid high and stall low.
// Registers: input register, then result register; an accepted word moves on
// into the result register once that is free, setting out_valid. Throughput:
// one word per cycle while no stalled result holds the result register.
// A stalled result holds; the input register keeps one word and in_stall
// rises only when both registers are full.
// Reset (rst, synchronous): idle, SCL and SDA drive state released high, stored
// ack 1, no result pending. Commands offered while a sequence runs are ignored.
`default_nettype none

module i2c_master_bit_sequencer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       cmd_valid,
  input  wire logic [2:0] mode,
  input  wire logic [7:0] tx_byte,
  input  wire logic       ack_level,
  input  wire logic       sda_sampled,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            scl_level,
  output logic            sda_level,
  output logic            busy_res,
  output logic            done_res,
  output logic [7:0]      rx_byte,
  output logic            ack_seen
);
  import i2cbs_pkg::*;

  logic         in_q_valid;
  logic         cmd_valid_q;
  logic [2:0]   mode_q;
  logic [7:0]   tx_byte_q;
  logic         ack_level_q;
  logic         sda_sampled_q;
  seq_state_t   state;
  seq_state_t   state_next;
  step_result_t res_next;
  logic         out_free;
  logic         fire;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !out_free;
  assign fire     = in_q_valid && out_free;

  i2cbs_step u_step (
    .cur         (state),
    .cmd_valid   (cmd_valid_q),
    .mode        (mode_q),
    .tx_byte     (tx_byte_q),
    .ack_level   (ack_level_q),
    .sda_sampled (sda_sampled_q),
    .nxt         (state_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_valid_q   <= cmd_valid;
      mode_q        <= mode;
      tx_byte_q     <= tx_byte;
      ack_level_q   <= ack_level;
      sda_sampled_q <= sda_sampled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.active_mode <= MODE_START;
      state.step_count  <= 5'd0;
      state.phase       <= 2'd0;
      state.running     <= 1'b0;
      state.shift_data  <= 8'd0;
      state.ack_store   <= 1'b1;
      state.scl_drive   <= 1'b1;
      state.sda_drive   <= 1'b1;
      out_valid         <= 1'b0;
    end else if (fire) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      scl_level <= res_next.scl_level;
      sda_level <= res_next.sda_level;
      busy_res  <= res_next.busy_res;
      done_res  <= res_next.done_res;
      rx_byte   <= res_next.rx_byte;
      ack_seen  <= res_next.ack_seen;
    end
  end

endmodule

`default_nettype wire

// ===== dv/i2c_bus_step_checker.sv =====
// i2c_bus_step_checker: watches both word channels of the I2C master bit
// sequencer, predicts each bus step and compares the result words field by field.
// Depends on i2cbs_pkg for the command codes and the result word type.
module i2c_bus_step_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       cmd_valid,
  input  logic [2:0] mode,
  input  logic [7:0] tx_byte,
  input  logic       ack_level,
  input  logic       sda_sampled,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       scl_level,
  input  logic       sda_level,
  input  logic       busy_res,
  input  logic       done_res,
  input  logic [7:0] rx_byte,
  input  logic       ack_seen,
  output int         fail_count,
  output int         steps_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbs_pkg::*;

  logic [2:0] cur_mode;
  logic [4:0] cur_step;
  logic       seq_on;
  logic [7:0] shift_q;
  logic       ack_q;
  logic       scl_q;
  logic       sda_q;

  step_result_t expected_steps[$];

  task automatic advance_bus(input logic cv, input logic [2:0] md, input logic [7:0] txb,
                             input logic al, input logic sd, output step_result_t r);
    logic last;
    int   bit_idx;
    r = '0;
    last = 1'b0;
    if (!seq_on && cv && md <= MODE_SACK) begin
      cur_mode = md;
      cur_step = '0;
      seq_on = 1'b1;
      if (md == MODE_WRITE) shift_q = txb;
      else if (md == MODE_READ) shift_q = '0;
    end
    if (seq_on) begin
      r.busy_res = 1'b1;
      case (cur_mode)
        MODE_START: begin
          case (cur_step)
            5'd0: scl_q = 1'b1;
            5'd1: sda_q = 1'b1;
            5'd2: sda_q = 1'b0;
            default: scl_q = 1'b0;
          endcase
          last = (cur_step == 5'd3);
        end
        MODE_STOP: begin
          case (cur_step)
            5'd0: sda_q = 1'b0;
            5'd1: scl_q = 1'b1;
            default: sda_q = 1'b1;
          endcase
          last = (cur_step == 5'd2);
        end
        MODE_WRITE: begin
          bit_idx = cur_step / 3;
          case (cur_step % 3)
            0: sda_q = shift_q[7 - bit_idx];
            1: scl_q = 1'b1;
            default: scl_q = 1'b0;
          endcase
          last = (cur_step == 5'd23);
        end
        MODE_READ: begin
          if (cur_step == 5'd0) begin
            sda_q = 1'b1;
          end else begin
            case ((cur_step - 5'd1) % 3)
              0: scl_q = 1'b1;
              1: shift_q = {shift_q[6:0], sd};
              default: scl_q = 1'b0;
            endcase
          end
          last = (cur_step == 5'd24);
        end
        MODE_RACK: begin
          case (cur_step)
            5'd0: sda_q = 1'b1;
            5'd1: scl_q = 1'b1;
            5'd2: ack_q = sd;
            default: scl_q = 1'b0;
          endcase
          last = (cur_step == 5'd3);
        end
        default: begin
          case (cur_step)
            5'd0: sda_q = al;
            5'd1: scl_q = 1'b1;
            default: scl_q = 1'b0;
          endcase
          last = (cur_step == 5'd2);
        end
      endcase
      if (last) begin
        r.done_res = 1'b1;
        if (cur_mode == MODE_READ) r.rx_byte = shift_q;
        seq_on = 1'b0;
        cur_step = '0;
      end else begin
        cur_step = cur_step + 5'd1;
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.ack_seen  = ack_q;
  endtask

  always @(posedge clk) begin
    step_result_t want;
    step_result_t got;
    string        bad;
    if (rst) begin
      cur_mode = MODE_START;
      cur_step = '0;
      seq_on = 1'b0;
      shift_q = '0;
      ack_q = 1'b1;
      scl_q = 1'b1;
      sda_q = 1'b1;
      expected_steps.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{scl_level, sda_level, busy_res, done_res, rx_byte, ack_seen};
        if (expected_steps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ack=%0b",
                     got.scl_level, got.sda_level, got.busy_res, got.done_res,
                     got.rx_byte, got.ack_seen);
        end else begin
          want = expected_steps.pop_front();
          bad = "";
          if (got.scl_level !== want.scl_level) bad = {bad, " scl_level"};
          if (got.sda_level !== want.sda_level) bad = {bad, " sda_level"};
          if (got.busy_res !== want.busy_res) bad = {bad, " busy_res"};
          if (got.done_res !== want.done_res) bad = {bad, " done_res"};
          if (got.rx_byte !== want.rx_byte) bad = {bad, " rx_byte"};
          if (got.ack_seen !== want.ack_seen) bad = {bad, " ack_seen"};
          if (bad != "") begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("word %0d mismatch on%s", steps_checked, bad);
              $display("  exp scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ack=%0b",
                       want.scl_level, want.sda_level, want.busy_res,
                       want.done_res, want.rx_byte, want.ack_seen);
              $display("  got scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ack=%0b",
                       got.scl_level, got.sda_level, got.busy_res,
                       got.done_res, got.rx_byte, got.ack_seen);
            end
          end
        end
        steps_checked <= steps_checked + 1;
      end
      if (in_valid && !in_stall) begin
        advance_bus(cmd_valid, mode, tx_byte, ack_level, sda_sampled, want);
        expected_steps.push_back(want);
      end
    end
  end

endmodule

// ===== dv/tb_i2c_master_bit_sequencer.sv =====
// tb_i2c_master_bit_sequencer: drives bus-step words into the I2C master bit
// sequencer with random gaps and stalls; i2c_bus_step_checker predicts and compares.
// Depends on i2cbs_pkg, i2c_master_bit_sequencer and i2c_bus_step_checker.
module tb_i2c_master_bit_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbs_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int RAND_STEPS  = 480;
  localparam logic [2:0] MODE_BAD_LO = 3'd6;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd_valid = 1'b0;
  logic [2:0] mode = MODE_START;
  logic [7:0] tx_byte = '0;
  logic       ack_level = 1'b0;
  logic       sda_sampled = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;

  int  fail_count;
  int  steps_checked;
  int  steps_sent = 0;
  int  cycles = 0;
  logic calm;

  assign calm = (steps_sent >= 300 && steps_sent < 450);

  i2c_master_bit_sequencer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd_valid(cmd_valid), .mode(mode), .tx_byte(tx_byte),
    .ack_level(ack_level), .sda_sampled(sda_sampled),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_level(scl_level), .sda_level(sda_level), .busy_res(busy_res),
    .done_res(done_res), .rx_byte(rx_byte), .ack_seen(ack_seen)
  );

  i2c_bus_step_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd_valid(cmd_valid), .mode(mode), .tx_byte(tx_byte),
    .ack_level(ack_level), .sda_sampled(sda_sampled),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_level(scl_level), .sda_level(sda_level), .busy_res(busy_res),
    .done_res(done_res), .rx_byte(rx_byte), .ack_seen(ack_seen),
    .fail_count(fail_count), .steps_checked(steps_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    out_stall <= !calm && ($urandom_range(0, 99) < 33);

  function automatic int cmd_steps(input logic [2:0] md);
    case (md)
      MODE_START: return 4;
      MODE_STOP:  return 3;
      MODE_WRITE: return 24;
      MODE_READ:  return 25;
      MODE_RACK:  return 4;
      MODE_SACK:  return 3;
      default:    return 1;
    endcase
  endfunction

  task automatic put_step(input logic cv, input logic [2:0] md, input logic [7:0] txb,
                          input logic al, input logic sd);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd_valid   <= cv;
    mode        <= md;
    tx_byte     <= txb;
    ack_level   <= al;
    sda_sampled <= sd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    steps_sent++;
  endtask

  // first word carries the command; the rest are bus steps, optionally with
  // commands that must be ignored while busy
  task automatic run_command(input logic [2:0] md, input logic [7:0] txb, input logic al,
                             input int sda_pat, input bit noisy);
    int   n;
    logic sd;
    n = cmd_steps(md);
    for (int i = 0; i < n; i++) begin
      sd = (sda_pat == SDA_RAND) ? 1'($urandom_range(0, 1)) : (sda_pat == SDA_HIGH);
      if (i == 0)
        put_step(1'b1, md, txb, al, sd);
      else if (noisy && $urandom_range(0, 1))
        put_step(1'b1, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), sd);
      else
        put_step(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), sd);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (steps_checked != steps_sent) @(posedge clk);
  endtask

  initial begin
    int pick;
    int goal;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    put_step(1'b0, MODE_START, 8'h00, 1'b0, 1'b0);
    run_command(MODE_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_command(MODE_WRITE, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_command(MODE_RACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
    run_command(MODE_WRITE, 8'hFF, 1'b1, SDA_RAND, 1'b1);
    run_command(MODE_RACK, 8'hFF, 1'b0, SDA_HIGH, 1'b1);
    run_command(MODE_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b0);
    run_command(MODE_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_command(MODE_SACK, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_command(MODE_READ, 8'hFF, 1'b1, SDA_LOW, 1'b1);
    run_command(MODE_SACK, 8'h00, 1'b1, SDA_RAND, 1'b1);
    run_command(MODE_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
    put_step(1'b1, MODE_BAD_LO, 8'h5A, 1'b1, 1'b1);
    put_step(1'b1, MODE_BAD_HI, 8'hC3, 1'b0, 1'b0);
    put_step(1'b0, MODE_STOP, 8'hFF, 1'b1, 1'b1);
    run_command(MODE_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

    // hold off until the sequencer has answered every word
    drain();

    goal = steps_sent + RAND_STEPS;
    while (steps_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        run_command(3'($urandom_range(0, 5)), 8'($urandom), 1'($urandom),
                    ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1)) : SDA_RAND,
                    $urandom_range(0, 3) == 0);
      else if (pick < 92)
        put_step(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
      else
        put_step(1'b1, $urandom_range(0, 1) ? MODE_BAD_HI : MODE_BAD_LO, 8'($urandom),
                 1'($urandom), 1'($urandom));
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
src/i2cbs_pkg.sv
src/i2cbs_step.sv
src/i2c_master_bit_sequencer.sv
dv/i2c_bus_step_checker.sv
dv/tb_i2c_master_bit_sequencer.sv
